// File: sv/lru_key_value_cache_assert.svh
// assertion macros for the lru key/value cache
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
// property that holds at every clock edge out of reset
`define LKV_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked in the cycle after its trigger
`define LKV_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define LKV_ASSERT(name, prop, msg)
`define LKV_ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

// File: sv/lkv_pkg.sv
// shared types and constants of the lru key/value cache
`default_nettype none
package lkv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int CAP_BITS    = 5;
    localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_RESET   = 16;

    typedef logic [KEY_BITS-1:0]          key_t;
    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_BITS-1:0]          count_t;
    typedef logic [CAP_BITS-1:0]          cap_t;

    // answer on a get miss and on every put
    localparam value_t NO_VALUE = '1;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } command_t;

    // per-cell control from the top level
    typedef struct packed {
        logic update;   // state changes this cycle
        logic valid;    // cell holds a live entry
        logic is_top;   // cell receives the most recent entry
    } cell_ctrl_t;

endpackage
`default_nettype wire

// File: sv/lkv_if.sv
// request and response channel interfaces
`default_nettype none
interface lkv_req_if;
    logic              valid;
    logic              ready;
    lkv_pkg::command_t command;
    lkv_pkg::key_t     key;
    lkv_pkg::value_t   value;

    modport source (output valid, command, key, value, input ready);
    modport sink   (input valid, command, key, value, output ready);
endinterface

interface lkv_rsp_if;
    logic            valid;
    logic            ready;
    logic            hit;
    lkv_pkg::value_t read_value;

    modport source (output valid, hit, read_value, input ready);
    modport sink   (input valid, hit, read_value, output ready);
endinterface
`default_nettype wire

// File: sv/lkv_cell.sv
// one slot of the recency stack: key, value, compare and shift
`default_nettype none
module lkv_cell (
    input  wire                 clk,
    input  lkv_pkg::cell_ctrl_t ctrl,
    input  lkv_pkg::key_t       req_key,
    input  lkv_pkg::value_t     new_value,
    input  lkv_pkg::key_t       up_key,
    input  lkv_pkg::value_t     up_value,
    input  logic                shift_in,
    output lkv_pkg::key_t       key,
    output lkv_pkg::value_t     value,
    output logic                match,
    output logic                shift_out
);

    lkv_pkg::key_t   key_reg;
    lkv_pkg::key_t   key_next;
    lkv_pkg::value_t value_reg;
    lkv_pkg::value_t value_next;

    assign match     = ctrl.valid && (key_reg == req_key);
    // a slot at or above the removed one takes its upper neighbor
    assign shift_out = ctrl.valid && (shift_in || match);

    always_comb
    begin
        priority if (ctrl.is_top)
        begin
            key_next   = req_key;
            value_next = new_value;
        end
        else if (shift_out)
        begin
            key_next   = up_key;
            value_next = up_value;
        end
        else
        begin
            key_next   = key_reg;
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.update)
        begin
            key_reg   <= key_next;
            value_reg <= value_next;
        end
    end

    assign key   = key_reg;
    assign value = value_reg;

endmodule
`default_nettype wire

// File: sv/lru_key_value_cache.sv
// top level of the lru key/value cache
`default_nettype none
// Fully associative key/value cache with least-recently-used replacement,
// built as a row of MAX_ENTRIES cells kept in recency order (cell 0 least
// recent). A get or put transaction is compared against all live cells at
// once; on a hit the matching entry leaves its slot, the more recent cells
// slide down by one and the entry re-enters at the most recent end. A put
// of a new key appends it, or drops cell 0 first once the entry count has
// reached the capacity register (0 reads as 1, values above MAX_ENTRIES
// saturate). The stack is updated at the accepting edge and the response
// sits in an output register, so a new request is taken every cycle while
// the response side keeps up. The speed is set by the parallel key compare
// and the shift-enable chain across the cells. The user must write capacity
// through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce
// this. Lowering it never drops entries at the write itself.
module lru_key_value_cache (
    input  wire                     clk,
    input  wire                     rst_n,
    lkv_req_if.sink                 req,
    lkv_rsp_if.source               rsp,
    input  wire                     cfg_wr_en,
    input  wire [lkv_pkg::CAP_BITS-1:0] cfg_wr_data
);

    localparam int N = lkv_pkg::MAX_ENTRIES;

    // configuration and fill state
    lkv_pkg::cap_t   cap_reg;
    lkv_pkg::count_t count_reg;
    lkv_pkg::count_t count_next;
    lkv_pkg::count_t limit;
    lkv_pkg::count_t top_idx;

    // response register
    logic            rsp_valid_reg;
    logic            rsp_hit_reg;
    lkv_pkg::value_t rsp_value_reg;

    // cell row
    lkv_pkg::cell_ctrl_t ctrl_vec  [N];
    lkv_pkg::key_t       key_vec   [N];
    lkv_pkg::value_t     value_vec [N];
    logic [N-1:0]        match_vec;
    logic [N:0]          shift_chain;

    logic            req_accept;
    logic            is_put;
    logic            hit_any;
    logic            evict;
    logic            fill;
    logic            update;
    lkv_pkg::value_t hit_value;
    lkv_pkg::value_t new_value;

    assign req.ready  = !rsp_valid_reg || rsp.ready;
    assign req_accept = req.valid && req.ready;
    assign is_put     = (req.command == lkv_pkg::CMD_PUT);

    // effective capacity: zero acts as one, saturate at the row length
    always_comb
    begin
        priority if (cap_reg == '0)
            limit = lkv_pkg::count_t'(1);
        else if (32'(cap_reg) > N)
            limit = lkv_pkg::count_t'(N);
        else
            limit = lkv_pkg::count_t'(cap_reg);
    end

    assign hit_any = |match_vec;

    // keys are unique, so at most one cell contributes
    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < N; i++)
        begin
            if (match_vec[i])
                hit_value = hit_value | value_vec[i];
        end
    end

    // new key with the store full: least recent entry goes
    assign evict     = is_put && !hit_any && (count_reg >= limit) && (count_reg != '0);
    assign fill      = req_accept && is_put && !hit_any && !evict;
    assign update    = req_accept && (is_put || hit_any);
    assign new_value = is_put ? req.value : hit_value;

    // slot that receives the most recent entry
    assign top_idx = (hit_any || evict) ? count_reg - lkv_pkg::count_t'(1) : count_reg;

    assign count_next = fill ? count_reg + lkv_pkg::count_t'(1) : count_reg;

    // eviction starts the shift at cell 0
    assign shift_chain[0] = evict;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        lkv_pkg::key_t   up_key;
        lkv_pkg::value_t up_value;

        if (i == N - 1)
        begin : g_last
            // nothing above the last cell; it never shifts
            assign up_key   = '0;
            assign up_value = '0;
        end
        else
        begin : g_mid
            assign up_key   = key_vec[i+1];
            assign up_value = value_vec[i+1];
        end

        assign ctrl_vec[i].update = update;
        assign ctrl_vec[i].valid  = lkv_pkg::count_t'(i) < count_reg;
        assign ctrl_vec[i].is_top = top_idx == lkv_pkg::count_t'(i);

        lkv_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl_vec[i]),
            .req_key   (req.key),
            .new_value (new_value),
            .up_key    (up_key),
            .up_value  (up_value),
            .shift_in  (shift_chain[i]),
            .key       (key_vec[i]),
            .value     (value_vec[i]),
            .match     (match_vec[i]),
            .shift_out (shift_chain[i+1])
        );
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lkv_pkg::cap_t'(lkv_pkg::CAP_RESET);
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            count_reg <= count_next;
            if (req_accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            rsp_hit_reg   <= hit_any;
            rsp_value_reg <= (hit_any && !is_put) ? hit_value : lkv_pkg::NO_VALUE;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.hit        = rsp_hit_reg;
    assign rsp.read_value = rsp_value_reg;

    `include "lru_key_value_cache_assert.svh"

    `LKV_ASSERT(a_one_match, $onehot0(match_vec), "key matched in more than one cell")
    `LKV_ASSERT_NEXT(a_fill_count, fill, count_reg == $past(count_reg) + lkv_pkg::count_t'(1), "fill did not grow the count")
    `LKV_ASSERT_NEXT(a_rsp_valid, req_accept, rsp.valid, "accepted request left no response")
    `LKV_ASSERT_NEXT(a_get_hit_value, req_accept && !is_put && hit_any, rsp.read_value == $past(hit_value), "get hit returned the wrong value")

endmodule
`default_nettype wire

// File: verif/lru_cache_checker.sv
// checker for the lru key/value cache: predicts each response and compares it
`default_nettype none
module lru_cache_checker (
    input  wire        clk,
    input  wire        rst_n,
    lkv_req_if         req,
    lkv_rsp_if         rsp,
    input  wire        cfg_wr_en,
    input  wire [lkv_pkg::CAP_BITS-1:0] cfg_wr_data,
    output int         error_count,
    output int         pending_results,
    output int         hit_total,
    output int         evict_total
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic            hit;
        lkv_pkg::value_t read_value;
    } lookup_result_t;

    // recency order: index 0 least recent
    lkv_pkg::key_t   lru_keys[$];
    lkv_pkg::value_t lru_values[$];
    lkv_pkg::cap_t   capacity_reg;
    lookup_result_t  expected_results[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    function automatic int effective_capacity();
        int lim;
        lim = int'(capacity_reg);
        if (lim == 0)
            lim = 1;
        if (lim > lkv_pkg::MAX_ENTRIES)
            lim = lkv_pkg::MAX_ENTRIES;
        return lim;
    endfunction

    // append one entry at the most recent end
    function automatic void add_recent(lkv_pkg::key_t k, lkv_pkg::value_t v);
        lru_keys.insert(lru_keys.size(), k);
        lru_values.insert(lru_values.size(), v);
    endfunction

    // apply one get/put to the predicted store and return its response
    function automatic lookup_result_t lookup_and_update(lkv_pkg::command_t cmd,
                                                         lkv_pkg::key_t k,
                                                         lkv_pkg::value_t v);
        lookup_result_t  res;
        int              pos;
        lkv_pkg::value_t stored;
        pos = -1;
        stored = '0;
        for (int i = 0; i < lru_keys.size(); i++)
        begin
            if (lru_keys[i] == k)
            begin
                pos = i;
                break;
            end
        end
        if (pos >= 0)
        begin
            stored = lru_values[pos];
            lru_keys.delete(pos);
            lru_values.delete(pos);
            add_recent(k, (cmd == lkv_pkg::CMD_PUT) ? v : stored);
        end
        else if (cmd == lkv_pkg::CMD_PUT)
        begin
            if (lru_keys.size() >= effective_capacity() && lru_keys.size() > 0)
            begin
                void'(lru_keys.pop_front());
                void'(lru_values.pop_front());
                evict_total++;
            end
            if (lru_keys.size() < lkv_pkg::MAX_ENTRIES)
                add_recent(k, v);
        end
        res.hit = (pos >= 0);
        res.read_value = (pos >= 0 && cmd == lkv_pkg::CMD_GET) ? stored : lkv_pkg::NO_VALUE;
        return res;
    endfunction

    initial
    begin
        error_count = 0;
        pending_results = 0;
        hit_total = 0;
        evict_total = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t want;
        if (!rst_n)
        begin
            lru_keys.delete();
            lru_values.delete();
            expected_results.delete();
            capacity_reg = lkv_pkg::cap_t'(lkv_pkg::CAP_RESET);
            pending_results = 0;
        end
        else
        begin
            if (cfg_wr_en)
                capacity_reg = cfg_wr_data;

            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("response with no request outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.hit !== want.hit)
                        report_mismatch($sformatf("hit: got %b, expected %b",
                                                  rsp.hit, want.hit));
                    if (rsp.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value: got %h, expected %h",
                                                  rsp.read_value, want.read_value));
                end
            end

            if (req.valid && req.ready)
            begin
                want = lookup_and_update(req.command, req.key, req.value);
                if (want.hit)
                    hit_total++;
                expected_results.insert(expected_results.size(), want);
            end
            pending_results = expected_results.size();
        end
    end
endmodule
`default_nettype wire

// File: verif/tb_lru_key_value_cache.sv
// testbench top for the lru key/value cache: stimulus, idling and verdict
`default_nettype none
module tb_lru_key_value_cache;
    timeunit 1ns;
    timeprecision 1ps;

    // generous bound: ~1800 transactions, each with a random gap and stall
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 145;
    localparam int POOL_MAX     = 24;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          cfg_wr_en;
    lkv_pkg::cap_t cfg_wr_data;

    lkv_req_if req_ch();
    lkv_rsp_if rsp_ch();

    int error_count;
    int pending_results;
    int hit_total;
    int evict_total;
    int cycle_count = 0;
    int requests_sent = 0;
    int capacity_writes = 0;

    // when set, neither side idles: back-to-back transactions
    bit            no_idle = 1'b0;
    lkv_pkg::key_t key_pool[POOL_MAX];
    int            pool_size;
    lkv_pkg::key_t last_key;

    always #4 clk = ~clk;

    lru_key_value_cache DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    lru_cache_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .error_count     (error_count),
        .pending_results (pending_results),
        .hit_total       (hit_total),
        .evict_total     (evict_total)
    );

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one request transaction: optional gap, then hold valid until accepted;
    // returns at the falling edge after the accepting edge
    task automatic send_request(lkv_pkg::command_t cmd, lkv_pkg::key_t k,
                                lkv_pkg::value_t v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.key     <= k;
        req_ch.value   <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        last_key = k;
        requests_sent++;
    endtask

    // capacity only changes once every response is back
    task automatic write_capacity(lkv_pkg::cap_t cap);
        req_ch.valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        capacity_writes++;
    endtask

    // mostly keys from a small hot set so hits and evictions are frequent,
    // some repeats of the last key, a few fully random keys
    function automatic lkv_pkg::key_t pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return key_pool[$urandom_range(0, pool_size - 1)];
        else if (r < 90)
            return last_key;
        else
            return lkv_pkg::key_t'($urandom);
    endfunction

    // response side: random stall per transaction, ready held until taken
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready));
        end
    end

    initial
    begin
        lkv_pkg::cap_t     cap;
        lkv_pkg::command_t cmd;
        int                put_pct;

        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        req_ch.valid   = 1'b0;
        req_ch.command = lkv_pkg::CMD_GET;
        req_ch.key     = '0;
        req_ch.value   = '0;
        rsp_ch.ready   = 1'b0;
        last_key       = '0;
        pool_size      = 1;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: get on an empty store, extreme keys and values
        send_request(lkv_pkg::CMD_GET, '0, 32'sd5);
        send_request(lkv_pkg::CMD_PUT, '0, 32'sh8000_0000);
        send_request(lkv_pkg::CMD_PUT, '1, 32'sh7FFF_FFFF);
        send_request(lkv_pkg::CMD_GET, '0, '0);
        // update in place, then a hit whose stored value looks like a miss
        send_request(lkv_pkg::CMD_PUT, '0, -32'sd1);
        send_request(lkv_pkg::CMD_GET, '0, '0);
        send_request(lkv_pkg::CMD_GET, '1, '0);
        send_request(lkv_pkg::CMD_PUT, 32'hAAAA_AAAA, 32'sh5555_5555);
        send_request(lkv_pkg::CMD_PUT, 32'h5555_5555, 32'shAAAA_AAAA);
        // fill all sixteen slots at the reset capacity
        for (int i = 0; i < 12; i++)
            send_request(lkv_pkg::CMD_PUT, lkv_pkg::key_t'(32'h100 + i),
                         lkv_pkg::value_t'(i));
        // store full: new key evicts key 0, the least recent, so it now misses
        send_request(lkv_pkg::CMD_PUT, 32'hDEAD_BEEF, 32'sd7);
        send_request(lkv_pkg::CMD_GET, '0, '0);

        // capacity lowered below the held count: nothing dropped at the write,
        // old entries still hit, a new key evicts exactly one
        write_capacity(lkv_pkg::cap_t'(2));
        send_request(lkv_pkg::CMD_GET, 32'hAAAA_AAAA, '0);
        send_request(lkv_pkg::CMD_PUT, 32'h0BAD_F00D, 32'sd9);
        send_request(lkv_pkg::CMD_GET, '1, '0);
        send_request(lkv_pkg::CMD_GET, 32'h100, '0);

        // random phases, each under a new capacity; zero and values above
        // the slot count are included, as are the bounds
        for (int p = 0; p < PHASES; p++)
        begin
            unique case (p)
                0:       cap = lkv_pkg::cap_t'(0);
                1:       cap = lkv_pkg::cap_t'(31);
                2:       cap = lkv_pkg::cap_t'(1);
                3:       cap = lkv_pkg::cap_t'(16);
                default: cap = lkv_pkg::cap_t'($urandom_range(0, 31));
            endcase
            write_capacity(cap);

            no_idle   = ($urandom_range(0, 3) == 0);
            put_pct   = $urandom_range(25, 75);
            pool_size = $urandom_range(1, POOL_MAX);
            // refresh part of the hot set so old entries age out
            for (int i = 0; i < POOL_MAX; i++)
                if (p == 0 || $urandom_range(0, 1) == 0)
                    key_pool[i] = lkv_pkg::key_t'($urandom);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                cmd = ($urandom_range(0, 99) < put_pct) ? lkv_pkg::CMD_PUT
                                                        : lkv_pkg::CMD_GET;
                send_request(cmd, pick_key(), lkv_pkg::value_t'($urandom));
            end
        end
        req_ch.valid <= 1'b0;
        no_idle = 1'b0;

        // drain: every response back, then an idle wait for stray output
        while (pending_results != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("covered %0d get/put transactions over %0d capacity settings",
                 requests_sent, capacity_writes);
        $display("lookups hit %0d times; %0d puts evicted the least recent entry",
                 hit_total, evict_total);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
